// File: rtl/core/spectrum_decay_peak_hold_core_macros.svh
// Assertion macros shared by the checker of spectrum_decay_peak_hold_core
`ifndef SPECTRUM_DECAY_PEAK_HOLD_CORE_MACROS_SVH
`define SPECTRUM_DECAY_PEAK_HOLD_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SDPH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdph assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SDPH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdph assertion failed");

`endif

// File: rtl/core/sdph_pkg.sv
// Package: types, constants and the Wi-Fi lookup table of the peak-hold core
`timescale 1ns / 1ps
package sdph_pkg;

  localparam int NumChannelsDef = 126;
  localparam int ChW            = 7;
  localparam int LvlW           = 8;
  localparam int WifiW          = 4;
  localparam int PhaseW         = 2;
  localparam int WifiCount      = 14;
  localparam int LutDepth       = 2 ** ChW;

  localparam logic [LvlW-1:0] LevelMax   = 8'd255;
  localparam logic [LvlW-1:0] DecayReset = 8'd15;

  // Configuration register indexes
  localparam logic CfgEnable = 1'b0;
  localparam logic CfgDecay  = 1'b1;

  // Output tdata layout
  localparam int OutDataW = 32;

  // Centre channel of each Wi-Fi channel, entry 0 is Wi-Fi channel 1
  localparam logic [WifiCount-1:0][LvlW-1:0] WifiCentre = {
    8'd84, 8'd72, 8'd67, 8'd62, 8'd57, 8'd52, 8'd47,
    8'd42, 8'd37, 8'd32, 8'd27, 8'd22, 8'd17, 8'd12
  };

  typedef logic [LutDepth-1:0][WifiW-1:0] wifi_lut_t;

  typedef struct packed {
    logic             peak_drop;  // peak hold may fall this sweep
    logic             done;
    logic [LvlW-1:0]  sweep_max;
    logic [WifiW-1:0] wifi_channel;
  } sweep_status_t;

  // Nearest Wi-Fi channel per radio channel; strict compare keeps the lower one
  function automatic wifi_lut_t build_wifi_lut();
    wifi_lut_t       lut;
    logic [LvlW-1:0] best_gap;
    logic [LvlW-1:0] gap;
    logic [LvlW-1:0] chv;
    logic [WifiW-1:0] best;
    for (int c = 0; c < LutDepth; c++) begin
      best_gap = LevelMax;
      best     = '0;
      chv      = LvlW'(c);
      for (int i = 0; i < WifiCount; i++) begin
        gap = (chv >= WifiCentre[i]) ? chv - WifiCentre[i] : WifiCentre[i] - chv;
        if (gap < best_gap) begin
          best_gap = gap;
          best     = WifiW'(i + 1);
        end
      end
      lut[c] = best;
    end
    return lut;
  endfunction

  localparam wifi_lut_t WifiLut = build_wifi_lut();

endpackage

// File: rtl/core/spectrum_decay_peak_hold_core.sv
// Top level of the spectrum peak-hold core with per-channel decay
//
// Usage:
//   s_axis carries one detector sample per transaction: tdata[6:0] is the radio
//   channel, tdata[7] the detect bit. m_axis returns one result per sample taken
//   in: tdata[7:0] level, [15:8] peak hold, [23:16] sweep maximum, [27:24]
//   nearest Wi-Fi channel; tlast marks the last channel of a sweep.
//   Samples arriving while disabled, or for channels beyond the store, are
//   consumed and give no result.
//   The cfg port writes enable (index 0) and decay step (index 1); it is always
//   ready and should be used only while the core is idle.
//   Each sample passes the registered memory read, then the result register;
//   one sample per cycle is sustained while results are taken. The per-channel
//   read-modify-write runs from the registered memory read to the result
//   register, with the write forwarded when the next sample hits the same channel.
//   Reset clears both stores through per-entry valid bits, so samples are
//   taken from the first cycle after reset. When the receiver stalls, the
//   result is held and one further sample is kept in the core; s_axis_tready
//   drops until the result is taken.
`timescale 1ns / 1ps
module spectrum_decay_peak_hold_core #(
  parameter int NUM_CHANNELS = sdph_pkg::NumChannelsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_addr_i,
  input  logic [sdph_pkg::LvlW-1:0]        cfg_data_i,
  // samples in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // channel[6:0], detect[7]
  // results out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sdph_pkg::OutDataW-1:0]    m_axis_tdata,   // level, peak_hold,
                                                           // sweep_max, wifi_channel, 0
  output logic                             m_axis_tlast    // sweep_done
);
  import sdph_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic            enable_q;
  logic [LvlW-1:0] decay_q;

  logic [ChW-1:0]  in_ch;
  logic            in_det;
  logic            accept, take;

  logic            s1_valid_q;
  logic [ChW-1:0]  s1_ch_q;
  logic            s1_det_q;
  logic            s1_adv;

  logic [2*LvlW-1:0] rd_data;
  logic [LvlW-1:0]   lv_old, pk_old, lv_new, pk_new;
  sweep_status_t     sweep;

  logic                 m_valid_q;
  logic [OutDataW-1:0]  m_data_q;
  logic                 m_last_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      decay_q  <= DecayReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgEnable: enable_q <= cfg_data_i[0];
        CfgDecay:  decay_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // input stage
  assign in_ch  = s_axis_tdata[ChW-1:0];
  assign in_det = s_axis_tdata[ChW];

  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = accept && enable_q && ({1'b0, in_ch} < (ChW + 1)'(NUM_CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ch_q  <= in_ch;
      s1_det_q <= in_det;
    end
  end

  sdph_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .AW           (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (take),
    .rd_addr_i (in_ch[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_ch_q[AW-1:0]),
    .wr_data_i ({pk_new, lv_new})
  );

  // level and peak-hold update
  assign lv_old = rd_data[LvlW-1:0];
  assign pk_old = rd_data[2*LvlW-1:LvlW];

  always_comb begin
    if (s1_det_q) begin
      lv_new = LevelMax;
    end else if (lv_old > decay_q) begin
      lv_new = lv_old - decay_q;
    end else begin
      lv_new = '0;
    end

    if (lv_new > pk_old) begin
      pk_new = lv_new;
    end else if ((pk_old != '0) && sweep.peak_drop) begin
      pk_new = pk_old - LvlW'(1);
    end else begin
      pk_new = pk_old;
    end
  end

  sdph_sweep #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_adv),
    .channel_i (s1_ch_q),
    .level_i   (lv_new),
    .status_o  (sweep)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= {4'b0, sweep.wifi_channel, sweep.sweep_max, pk_new, lv_new};
      m_last_q <= sweep.done;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// File: rtl/core/sdph_store.sv
// Per-channel level and peak-hold memory with valid bits and write forwarding
`timescale 1ns / 1ps
module sdph_store #(
  parameter int NUM_CHANNELS = sdph_pkg::NumChannelsDef,
  parameter int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [2*sdph_pkg::LvlW-1:0]  rd_data_o,   // level [7:0], peak [15:8]
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [2*sdph_pkg::LvlW-1:0]  wr_data_i
);
  import sdph_pkg::*;

  localparam int DW = 2 * LvlW;

  logic [DW-1:0]           mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  logic [DW-1:0]           rd_data_q;
  logic                    rd_vld_q;
  logic                    fwd_q;
  logic [DW-1:0]           fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        // same channel written at the read edge: the memory still returns old data
        fwd_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);

endmodule

// File: rtl/core/sdph_sweep.sv
// Sweep tracking: running maximum, its channel, sweep phase and Wi-Fi lookup
`timescale 1ns / 1ps
module sdph_sweep #(
  parameter int NUM_CHANNELS = sdph_pkg::NumChannelsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [sdph_pkg::ChW-1:0]  channel_i,
  input  logic [sdph_pkg::LvlW-1:0] level_i,
  output sdph_pkg::sweep_status_t   status_o
);
  import sdph_pkg::*;

  localparam logic [ChW-1:0] LastCh = ChW'(NUM_CHANNELS - 1);

  logic [LvlW-1:0]   max_q, max_d, max_base;
  logic [ChW-1:0]    max_ch_q, max_ch_d, max_ch_base;
  logic [PhaseW-1:0] phase_q;
  logic              done;

  always_comb begin
    // channel 0 opens a new sweep
    max_base    = (channel_i == '0) ? '0 : max_q;
    max_ch_base = (channel_i == '0) ? '0 : max_ch_q;
    if (level_i > max_base) begin
      max_d    = level_i;
      max_ch_d = channel_i;
    end else begin
      max_d    = max_base;
      max_ch_d = max_ch_base;
    end
  end

  assign done = (channel_i == LastCh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= '0;
      max_ch_q <= '0;
      phase_q  <= '0;
    end else if (fire_i) begin
      max_q    <= max_d;
      max_ch_q <= max_ch_d;
      if (done) begin
        phase_q <= phase_q + PhaseW'(1);
      end
    end
  end

  assign status_o.peak_drop    = (phase_q == '0);
  assign status_o.done         = done;
  assign status_o.sweep_max    = done ? max_d : '0;
  assign status_o.wifi_channel = done ? WifiLut[max_ch_d] : '0;

endmodule

// File: rtl/core/sdph_checker.sv
// Port-level checker for the peak-hold core, bound to the top level
`timescale 1ns / 1ps
`include "spectrum_decay_peak_hold_core_macros.svh"
module sdph_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sdph_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import sdph_pkg::*;

  // a held result keeps its payload
  `SDPH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // input back-pressure only comes from a stalled result
  `SDPH_ASSERT_IMPL(a_bp_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // end of sweep: a real Wi-Fi channel, and the maximum covers this level
  `SDPH_ASSERT_IMPL(a_sweep_end, m_axis_tvalid && m_axis_tlast, (m_axis_tdata[27:24] != 4'd0) && (m_axis_tdata[27:24] <= 4'd14) && (m_axis_tdata[23:16] >= m_axis_tdata[7:0]))

  // mid-sweep results carry no sweep summary
  `SDPH_ASSERT_IMPL(a_mid_sweep, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[31:16] == 16'd0)

endmodule

bind spectrum_decay_peak_hold_core sdph_checker u_sdph_checker (.*);
